// File: rtl/core/weighted_cross_covariance_accumulator_unit_macros.svh
// assertion macros for the weighted cross-covariance accumulator
// included by rtl files that carry concurrent checks, no other dependencies
`ifndef WEIGHTED_CROSS_COVARIANCE_ACCUMULATOR_UNIT_MACROS_SVH
`define WEIGHTED_CROSS_COVARIANCE_ACCUMULATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define WCCA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked out of reset
`define WCCA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define WCCA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define WCCA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/wcca_pkg.sv
// shared widths and constants for the weighted cross-covariance accumulator
// no dependencies
package wcca_pkg;

    localparam int WEIGHT_W  = 16;
    localparam int COORD_W   = 20;
    localparam int ACC_W     = 64;
    localparam int IDX_W     = 4;
    localparam int NUM_SUMS  = 16;

    // shared multiplier operands and product
    localparam int MUL_A_W   = 40;
    localparam int MUL_B_W   = 21;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

    // product terms drop this many fraction bits with round half up
    localparam int PROD_SHIFT = 15;

    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 72;

    localparam logic [IDX_W-1:0] IDX_WEIGHT   = 4'd0;
    localparam logic [IDX_W-1:0] IDX_LAST_LIN = 4'd6;
    localparam logic [IDX_W-1:0] IDX_LAST     = 4'd15;

endpackage

// File: rtl/core/wcca_mul.sv
// shared signed multiplier with registered product
// depends on wcca_pkg
module wcca_mul (
    input  logic                                 aclk,
    input  logic signed [wcca_pkg::MUL_A_W-1:0]  op_a,
    input  logic signed [wcca_pkg::MUL_B_W-1:0]  op_b,
    output logic signed [wcca_pkg::MUL_P_W-1:0]  prod
);

    logic signed [wcca_pkg::MUL_P_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

// File: rtl/core/weighted_cross_covariance_accumulator_unit.sv
// sequencing: a zero-weight word is skipped; any other word adds its weight into sum 0, then
// each linear sum passes MULB and ACC and each cross product MULA, MULB and ACC, all on one
// shared multiplier; a new word is taken only when idle, and a last word starts the emission
// emission: 16 result words, one per cycle while m_tready is high, sums cleared as sent
// reset: aresetn synchronous active low, clears sequencer and all sixteen sums
// depends on wcca_pkg, wcca_mul and the assertion macro header
`include "weighted_cross_covariance_accumulator_unit_macros.svh"

module weighted_cross_covariance_accumulator_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input words
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // weight, src_x, src_y, src_z, dst_x, dst_y, dst_z
    input  logic [wcca_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tlast,    // last_point
    // result words
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // sum_index, sum_value, zero pad
    output logic [wcca_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tlast     // last_sum
);

    // one-hot sequencer states
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,   // waiting for a word
        ST_MULA = 5'b00010,   // src * dst into the multiplier
        ST_MULB = 5'b00100,   // value * weight into the multiplier
        ST_ACC  = 5'b01000,   // saturating add into the current sum
        ST_EMIT = 5'b10000    // sending the sixteen sums
    } state_t;

    state_t state_reg, state_next;
    logic [wcca_pkg::IDX_W-1:0] idx_reg, idx_next;

    // captured word
    logic [wcca_pkg::WEIGHT_W-1:0]       weight_reg;
    logic signed [wcca_pkg::COORD_W-1:0] src_reg [3];
    logic signed [wcca_pkg::COORD_W-1:0] dst_reg [3];
    logic                                last_reg;

    // the sixteen sums
    logic signed [wcca_pkg::ACC_W-1:0] acc_reg [wcca_pkg::NUM_SUMS];

    // input field split
    logic [wcca_pkg::WEIGHT_W-1:0] s_weight;
    logic                          s_accept;

    assign s_weight = s_tdata[15:0];
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            weight_reg <= s_weight;
            src_reg[0] <= s_tdata[35:16];
            src_reg[1] <= s_tdata[55:36];
            src_reg[2] <= s_tdata[75:56];
            dst_reg[0] <= s_tdata[95:76];
            dst_reg[1] <= s_tdata[115:96];
            dst_reg[2] <= s_tdata[135:116];
            last_reg   <= s_tlast;
        end
    end

    // operand select for the current sum
    logic signed [wcca_pkg::COORD_W-1:0] lin_coord;   // linear sums 1..6
    logic signed [wcca_pkg::COORD_W-1:0] prod_src;    // cross products, row
    logic signed [wcca_pkg::COORD_W-1:0] prod_dst;    // cross products, column

    always_comb begin
        case (idx_reg)
            4'd1:    lin_coord = src_reg[0];
            4'd2:    lin_coord = src_reg[1];
            4'd3:    lin_coord = src_reg[2];
            4'd4:    lin_coord = dst_reg[0];
            4'd5:    lin_coord = dst_reg[1];
            4'd6:    lin_coord = dst_reg[2];
            default: lin_coord = src_reg[0];
        endcase
        case (idx_reg)
            4'd10, 4'd11, 4'd12: prod_src = src_reg[1];
            4'd13, 4'd14, 4'd15: prod_src = src_reg[2];
            default:             prod_src = src_reg[0];
        endcase
        case (idx_reg)
            4'd8, 4'd11, 4'd14: prod_dst = dst_reg[1];
            4'd9, 4'd12, 4'd15: prod_dst = dst_reg[2];
            default:            prod_dst = dst_reg[0];
        endcase
    end

    // shared multiplier: first pass src*dst, second pass times weight
    logic signed [wcca_pkg::MUL_A_W-1:0] mul_a;
    logic signed [wcca_pkg::MUL_B_W-1:0] mul_b;
    logic signed [wcca_pkg::MUL_P_W-1:0] mul_p;
    logic                                is_prod;

    assign is_prod = (idx_reg > wcca_pkg::IDX_LAST_LIN);

    always_comb begin
        if (state_reg == ST_MULA) begin
            mul_a = {{(wcca_pkg::MUL_A_W-wcca_pkg::COORD_W){prod_src[wcca_pkg::COORD_W-1]}},
                     prod_src};
            mul_b = {{(wcca_pkg::MUL_B_W-wcca_pkg::COORD_W){prod_dst[wcca_pkg::COORD_W-1]}},
                     prod_dst};
        end else begin
            // src*dst fits in the low operand bits
            mul_a = is_prod ? mul_p[wcca_pkg::MUL_A_W-1:0]
                  : {{(wcca_pkg::MUL_A_W-wcca_pkg::COORD_W){lin_coord[wcca_pkg::COORD_W-1]}},
                     lin_coord};
            mul_b = {{(wcca_pkg::MUL_B_W-wcca_pkg::WEIGHT_W){1'b0}}, weight_reg};
        end
    end

    wcca_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    // term for the current sum; product rounding is floor plus bit 14 as carry in
    logic signed [wcca_pkg::ACC_W-1:0] term;
    logic                              term_cin;

    always_comb begin
        if (idx_reg == wcca_pkg::IDX_WEIGHT) begin
            term     = {{(wcca_pkg::ACC_W-wcca_pkg::WEIGHT_W){1'b0}}, weight_reg};
            term_cin = 1'b0;
        end else if (!is_prod) begin
            term     = {{(wcca_pkg::ACC_W-wcca_pkg::MUL_P_W){mul_p[wcca_pkg::MUL_P_W-1]}},
                        mul_p};
            term_cin = 1'b0;
        end else begin
            term     = {{(wcca_pkg::ACC_W-wcca_pkg::MUL_P_W+wcca_pkg::PROD_SHIFT)
                         {mul_p[wcca_pkg::MUL_P_W-1]}},
                        mul_p[wcca_pkg::MUL_P_W-1:wcca_pkg::PROD_SHIFT]};
            term_cin = mul_p[wcca_pkg::PROD_SHIFT-1];
        end
    end

    // saturating add on 65 bits
    logic signed [wcca_pkg::ACC_W-1:0] acc_cur;
    logic [wcca_pkg::ACC_W:0]          sum_wide;
    logic [wcca_pkg::ACC_W-1:0]        sum_sat;

    assign acc_cur  = acc_reg[idx_reg];
    assign sum_wide = {acc_cur[wcca_pkg::ACC_W-1], acc_cur}
                    + {term[wcca_pkg::ACC_W-1], term}
                    + {{wcca_pkg::ACC_W{1'b0}}, term_cin};

    always_comb begin
        if (sum_wide[wcca_pkg::ACC_W] != sum_wide[wcca_pkg::ACC_W-1]) begin
            // overflow: clamp toward the sign of the exact sum
            sum_sat = sum_wide[wcca_pkg::ACC_W] ? {1'b1, {(wcca_pkg::ACC_W-1){1'b0}}}
                                                : {1'b0, {(wcca_pkg::ACC_W-1){1'b1}}};
        end else begin
            sum_sat = sum_wide[wcca_pkg::ACC_W-1:0];
        end
    end

    // sum write: update in ACC, clear as each sum is sent
    logic                              acc_we;
    logic signed [wcca_pkg::ACC_W-1:0] acc_wdata;

    assign acc_we    = (state_reg == ST_ACC) || ((state_reg == ST_EMIT) && m_tready);
    assign acc_wdata = (state_reg == ST_EMIT) ? '0 : sum_sat;

    // sequencer
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    idx_next = wcca_pkg::IDX_WEIGHT;
                    if (s_weight == '0) begin
                        // zero weight skips the pair
                        state_next = s_tlast ? ST_EMIT : ST_IDLE;
                    end else begin
                        state_next = ST_ACC;
                    end
                end
            end
            ST_MULA: begin
                state_next = ST_MULB;
            end
            ST_MULB: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                if (idx_reg == wcca_pkg::IDX_LAST) begin
                    idx_next   = wcca_pkg::IDX_WEIGHT;
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end else begin
                    idx_next   = idx_reg + 4'd1;
                    state_next = (idx_reg >= wcca_pkg::IDX_LAST_LIN) ? ST_MULA : ST_MULB;
                end
            end
            ST_EMIT: begin
                if (m_tready) begin
                    if (idx_reg == wcca_pkg::IDX_LAST) begin
                        idx_next   = wcca_pkg::IDX_WEIGHT;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
                idx_next   = wcca_pkg::IDX_WEIGHT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= wcca_pkg::IDX_WEIGHT;
            for (int k = 0; k < wcca_pkg::NUM_SUMS; k++) begin
                acc_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (acc_we) begin
                acc_reg[idx_reg] <= acc_wdata;
            end
        end
    end

    // ports
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata  = {{(wcca_pkg::M_TDATA_W-wcca_pkg::ACC_W-wcca_pkg::IDX_W){1'b0}},
                       acc_cur, idx_reg};
    assign m_tlast  = (idx_reg == wcca_pkg::IDX_LAST);

    // checks
    `WCCA_ASSERT_IMP(a_no_accept_while_sending, aclk, aresetn, s_tready, !m_tvalid)
    `WCCA_ASSERT_NXT(a_cleared_after_emit, aclk, aresetn, m_tvalid && m_tready && m_tlast, (acc_reg[wcca_pkg::IDX_LAST] == '0) && s_tready)
    `WCCA_ASSERT_NXT(a_acc_steps_index, aclk, aresetn, (state_reg == ST_ACC) && (idx_reg != wcca_pkg::IDX_LAST), idx_reg == ($past(idx_reg) + 4'd1))
    `WCCA_ASSERT_NXT(a_zero_weight_skips, aclk, aresetn, s_accept && (s_weight == '0) && !s_tlast, s_tready)

endmodule

// File: sim/tb.sv
// self-checking bench for weighted_cross_covariance_accumulator_unit: point pairs in, sixteen sums out
// depends on wcca_pkg and the rtl top level; predicts every sum word in a fixed-point model of its own
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_HALF      = 4;
    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          MAX_REPORTS   = 10;
    localparam int          RANDOM_PAIRS  = 425;
    localparam int          HOLD_AFTER    = 150;   // pairs taken before the long receive hold
    localparam int          HOLD_CYCLES   = 1500;
    localparam int          CALM_TAIL     = 60;    // last pairs run without any idling
    localparam int          DRAIN_CYCLES  = 60;    // settle time after every sum is returned
    localparam logic [19:0] COORD_MAX     = 20'h7FFFF;
    localparam logic [19:0] COORD_MIN     = 20'h80000;
    localparam logic [19:0] COORD_NEG1    = 20'hFFFFF;
    localparam logic [15:0] WEIGHT_ONE    = 16'h8000;
    localparam logic [15:0] WEIGHT_TOP    = 16'hFFFF;
    localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

    // one input word: coordinate index 0 is x, packed from the low bits up
    typedef struct packed {
        logic                            last;
        logic [2:0][19:0]                dst;
        logic [2:0][19:0]                src;
        logic [wcca_pkg::WEIGHT_W-1:0]   weight;
    } pair_t;

    // one emitted sum word
    typedef struct packed {
        logic [wcca_pkg::IDX_W-1:0]      idx;
        logic signed [63:0]              value;
        logic                            last;
    } sum_word_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [wcca_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic                            s_tlast  = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [wcca_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            m_tlast;

    pair_t              pending_pairs[$];
    sum_word_t          expected_sums[$];
    logic signed [63:0] cov_sums [wcca_pkg::NUM_SUMS] = '{default: '0};

    pair_t  cur_pair;
    int     n_pairs       = 0;
    int     pairs_taken   = 0;
    int     sums_seen     = 0;
    int     mismatches    = 0;
    int     cycle_cnt     = 0;
    int     send_gap      = 0;
    int     send_idle_pct = 20;
    int     recv_gap      = 0;
    int     recv_idle_pct = 20;
    int     hold_left     = 0;
    bit     hold_done     = 1'b0;
    bit     calm;

    // the last stretch of pairs goes through with both sides always ready
    assign calm = (n_pairs > 0) && (pairs_taken >= n_pairs - CALM_TAIL);

    weighted_cross_covariance_accumulator_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // weight, src_x, src_y, src_z, dst_x, dst_y, dst_z
        .s_tlast  (s_tlast),   // last_point
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // sum_index, sum_value, zero pad
        .m_tlast  (m_tlast)    // last_sum
    );

    always #(CLK_HALF) aclk = ~aclk;

    // run watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // signed 64-bit add that clamps at the limits instead of wrapping
    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] t;
        t = {a[63], a} + {b[63], b};
        if (t[64] != t[63])
            return t[64] ? SUM_MIN : SUM_MAX;
        return t[63:0];
    endfunction

    // add one pair into the running sums; on a last pair queue all sixteen and clear
    task automatic fold_in_pair(input pair_t p);
        logic signed [63:0] w;
        logic signed [63:0] a_c [3];
        logic signed [63:0] b_c [3];
        logic signed [63:0] prod;
        sum_word_t          s;
        w = {48'd0, p.weight};
        for (int i = 0; i < 3; i++) begin
            a_c[i] = {{44{p.src[i][19]}}, p.src[i]};
            b_c[i] = {{44{p.dst[i][19]}}, p.dst[i]};
        end
        // zero weight contributes nothing at all
        if (w != 0) begin
            cov_sums[wcca_pkg::IDX_WEIGHT] = sat_add64(cov_sums[wcca_pkg::IDX_WEIGHT], w);
            for (int i = 0; i < 3; i++) begin
                cov_sums[1 + i] = sat_add64(cov_sums[1 + i], w * a_c[i]);
                cov_sums[4 + i] = sat_add64(cov_sums[4 + i], w * b_c[i]);
            end
            // q.39 product down to q.24, half rounds toward plus infinity
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    prod = a_c[i] * b_c[j] * w;
                    prod = (prod + (64'sd1 <<< (wcca_pkg::PROD_SHIFT - 1)))
                           >>> wcca_pkg::PROD_SHIFT;
                    cov_sums[7 + 3 * i + j] = sat_add64(cov_sums[7 + 3 * i + j], prod);
                end
            end
        end
        if (p.last) begin
            for (int k = 0; k < wcca_pkg::NUM_SUMS; k++) begin
                s.idx   = k[wcca_pkg::IDX_W-1:0];
                s.value = cov_sums[k];
                s.last  = (s.idx == wcca_pkg::IDX_LAST);
                expected_sums.push_back(s);
                cov_sums[k] = '0;
            end
        end
    endtask

    function automatic pair_t mk_pair(input logic [15:0] w,
                                      input logic [19:0] sx, input logic [19:0] sy,
                                      input logic [19:0] sz, input logic [19:0] dx,
                                      input logic [19:0] dy, input logic [19:0] dz,
                                      input logic last);
        pair_t p;
        p.weight = w;
        p.src    = {sz, sy, sx};
        p.dst    = {dz, dy, dx};
        p.last   = last;
        return p;
    endfunction

    // mostly uniform coordinates, now and then a corner value
    function automatic logic [19:0] rand_coord();
        logic [19:0] corners [5];
        corners = '{COORD_MIN, COORD_MAX, 20'h0, 20'h1, COORD_NEG1};
        if ($urandom_range(99) < 10)
            return corners[$urandom_range(4)];
        return 20'($urandom_range(0, 20'hFFFFF));
    endfunction

    function automatic pair_t rand_pair(input logic last);
        pair_t       p;
        int unsigned r;
        logic [15:0] w;
        r = $urandom_range(99);
        if (r < 8)
            w = '0;                                    // skipped pair
        else if (r < 16)
            w = 16'($urandom_range(32769, 65535));     // weight above one
        else if (r < 22)
            w = ($urandom_range(1) != 0) ? WEIGHT_ONE : WEIGHT_TOP;
        else
            w = 16'($urandom_range(1, 32768));
        p = mk_pair(w, rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord(), last);
        return p;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on %s at word %0d: expected %h, got %h",
                     what, sums_seen, want, got);
    endtask

    // input driver: holds a word until taken, then maybe idles a burst
    always @(posedge aclk) begin : driver
        bit offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            offer = s_tvalid;
            if (s_tvalid && s_tready) begin
                fold_in_pair(cur_pair);
                pairs_taken <= pairs_taken + 1;
                offer = 1'b0;
                if (!calm && $urandom_range(99) < send_idle_pct)
                    send_gap = $urandom_range(1, 17);
                // switch idle density now and then, zero gives gapless stretches
                if (pairs_taken % 40 == 39)
                    send_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 60);
            end
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_pairs.size() != 0) begin
                    cur_pair = pending_pairs.pop_front();
                    s_tdata  <= {cur_pair.dst, cur_pair.src, cur_pair.weight};
                    s_tlast  <= cur_pair.last;
                    offer    = 1'b1;
                end
            end
            s_tvalid <= offer;
        end
    end

    // result monitor: checks each word taken and decides the next ready
    always @(posedge aclk) begin : monitor
        sum_word_t                  want;
        logic [wcca_pkg::IDX_W-1:0] got_idx;
        logic signed [63:0]         got_val;
        bit                         ready;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_idx = m_tdata[wcca_pkg::IDX_W-1:0];
                got_val = m_tdata[wcca_pkg::IDX_W +: wcca_pkg::ACC_W];
                if (expected_sums.size() == 0) begin
                    flag_mismatch("unexpected word", '0, {got_idx, 59'd0, m_tlast});
                end else begin
                    want = expected_sums.pop_front();
                    if (got_idx != want.idx)
                        flag_mismatch("sum_index", 64'(want.idx), 64'(got_idx));
                    if (got_val != want.value)
                        flag_mismatch($sformatf("sum_value[%0d]", want.idx), want.value,
                                      got_val);
                    if (m_tlast != want.last)
                        flag_mismatch("last_sum", 64'(want.last), 64'(m_tlast));
                end
                sums_seen++;
                if (sums_seen % 48 == 0)
                    recv_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 60);
            end
            // one long hold so the block backs up and stalls its input
            if (!hold_done && pairs_taken >= HOLD_AFTER) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready = 1'b0;
            end else if (calm) begin
                ready = 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap--;
                ready = 1'b0;
            end else if ($urandom_range(99) < recv_idle_pct) begin
                recv_gap = $urandom_range(0, 16);
                ready    = 1'b0;
            end else begin
                ready = 1'b1;
            end
            m_tready <= ready;
        end
    end

    initial begin : stimulus
        int counted;
        int len;
        pair_t p;

        // skipped pair with extreme coordinates, then an emission of a skipped-only set
        pending_pairs.push_back(mk_pair('0, COORD_MAX, COORD_MAX, COORD_MAX,
                                        COORD_MIN, COORD_MIN, COORD_MIN, 1'b0));
        pending_pairs.push_back(mk_pair('0, COORD_MIN, COORD_MAX, COORD_NEG1,
                                        COORD_MAX, COORD_MIN, 20'h1, 1'b1));
        // single-pair sets at the corners
        pending_pairs.push_back(mk_pair(WEIGHT_ONE, COORD_MAX, COORD_MAX, COORD_MAX,
                                        COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
        pending_pairs.push_back(mk_pair(WEIGHT_TOP, COORD_MIN, COORD_MIN, COORD_MIN,
                                        COORD_MIN, COORD_MIN, COORD_MIN, 1'b1));
        // opposite corners then a tiny weight, emitted together
        pending_pairs.push_back(mk_pair(WEIGHT_TOP, COORD_MIN, COORD_MIN, COORD_MIN,
                                        COORD_MAX, COORD_MAX, COORD_MAX, 1'b0));
        pending_pairs.push_back(mk_pair(16'h0001, COORD_MAX, COORD_MIN, COORD_MAX,
                                        COORD_MIN, COORD_MAX, COORD_MIN, 1'b1));
        // product rounding: exactly half, just below, just above, on both signs
        pending_pairs.push_back(mk_pair(16'd16384, 20'h1, COORD_NEG1, 20'h1,
                                        20'h1, 20'h1, COORD_NEG1, 1'b1));
        pending_pairs.push_back(mk_pair(16'd16383, 20'h1, COORD_NEG1, 20'h1,
                                        20'h1, 20'h1, COORD_NEG1, 1'b1));
        pending_pairs.push_back(mk_pair(16'd16385, 20'h1, COORD_NEG1, 20'h1,
                                        20'h1, 20'h1, COORD_NEG1, 1'b1));
        // origin with the smallest weight
        pending_pairs.push_back(mk_pair(16'h0001, '0, '0, '0, '0, '0, '0, 1'b1));
        // alternating bit patterns
        pending_pairs.push_back(mk_pair(16'hAAAA, 20'h55555, 20'hAAAAA, 20'h55555,
                                        20'hAAAAA, 20'h55555, 20'hAAAAA, 1'b0));
        pending_pairs.push_back(mk_pair(16'h5555, 20'hAAAAA, 20'h55555, 20'hAAAAA,
                                        20'h55555, 20'hAAAAA, 20'h55555, 1'b0));
        pending_pairs.push_back(mk_pair('0, 20'h12345, 20'h6789A, 20'hBCDEF,
                                        20'hFEDCB, 20'hA9876, 20'h54321, 1'b1));
        // back-to-back emissions, the second one of an empty set
        pending_pairs.push_back(mk_pair(WEIGHT_ONE, COORD_NEG1, 20'h1, COORD_MIN,
                                        COORD_MAX, COORD_NEG1, 20'h1, 1'b1));
        pending_pairs.push_back(mk_pair('0, '0, '0, '0, '0, '0, '0, 1'b1));

        // random sets, mostly short, a few long
        counted = 0;
        while (counted < RANDOM_PAIRS) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
                p = rand_pair(i == len - 1);
                pending_pairs.push_back(p);
                if (p.weight != 0 || p.last)
                    counted++;
            end
        end
        n_pairs = pending_pairs.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // all pairs taken and every sum returned, then let the pipe settle
        while (pending_pairs.size() != 0 || s_tvalid || expected_sums.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && expected_sums.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
